>>> src/ogi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ogi_pkg;

   localparam int MAX_WIDTH    = 512;
   localparam int MAX_RADIUS   = 8;
   localparam int HEIGHT_LIMIT = 512;
   localparam int SLOT_ROWS    = 2 * MAX_RADIUS + 2;
   localparam int WIN_SPAN     = 2 * MAX_RADIUS + 1;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int SLOT_W  = $clog2(SLOT_ROWS);
   localparam int DIM_W   = 10;
   localparam int ROW_W   = 10;
   localparam int RAD_W   = 4;
   localparam int OUT_W   = 9;
   localparam int RAW_W   = 8;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INFLATE_RADIUS = 2'd2;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 10'd512;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 10'd512;
   localparam logic [RAD_W-1:0] RADIUS_RESET = 4'd5;

   localparam logic [1:0] CLS_FREE    = 2'd0;
   localparam logic [1:0] CLS_OBST    = 2'd1;
   localparam logic [1:0] CLS_UNKNOWN = 2'd2;

   localparam logic signed [RAW_W-1:0] RAW_FREE     = 8'sd0;
   localparam logic signed [RAW_W-1:0] RAW_OCCUPIED = 8'sd100;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [1:0] cls_type;
   typedef cls_type [SLOT_ROWS-1:0] col_word_type;

   typedef struct packed {
      logic    pad;
      cls_type cls;
   } item_type;

   typedef struct packed {
      cls_type          cell_class;
      logic [OUT_W-1:0] out_row;
      logic [OUT_W-1:0] out_col;
      logic             frame_last;
   } rsp_type;

   typedef struct packed {
      logic                  we;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] wdata;
   } csr_type;

   function automatic cls_type classify(input logic signed [RAW_W-1:0] raw);
      cls_type c;
      if (raw == RAW_FREE) c = CLS_FREE;
      else if (raw == RAW_OCCUPIED) c = CLS_OBST;
      else c = CLS_UNKNOWN;
      return c;
   endfunction

endpackage

`default_nettype wire

>>> src/ogi_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ogi_front import ogi_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic                    req_mode,
   input  logic signed [RAW_W-1:0] req_cell_value,
   output logic                    item_valid,
   output item_type                item,
   input  logic                    item_pop
);

   item_type          q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] head_ff, head_in;
   logic [QPTR_W-1:0] tail_ff, tail_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push_ok;
   logic              pop_ok;

   assign req_full   = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = q_ff[head_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = item_pop && item_valid;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push_ok) begin
         tail_in = (tail_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (pop_ok) begin
         head_in = (head_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push_ok && !pop_ok) count_in = count_ff + 1'b1;
      else if (!push_ok && pop_ok) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[tail_ff] <= '{pad: req_mode, cls: classify(req_cell_value)};
      end
   end

endmodule

`default_nettype wire

>>> src/ogi_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ogi_back import ogi_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  csr_type  csr,
   input  logic     item_valid,
   input  item_type item,
   output logic     item_pop,
   input  logic     rsp_full,
   output logic     rsp_push,
   output rsp_type  rsp
);

   typedef struct packed {
      logic              valid;
      logic [COL_W-1:0]  col;
      logic [SLOT_W-1:0] slot;
      cls_type           cls;
   } wr_type;

   logic [DIM_W-1:0]  width_ff, width_in;
   logic [DIM_W-1:0]  height_ff, height_in;
   logic [RAD_W-1:0]  radius_ff, radius_in;
   logic [ROW_W-1:0]  in_row_ff, in_row_in;
   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [SLOT_W-1:0] in_slot_ff, in_slot_in;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [SLOT_W-1:0] out_slot_ff, out_slot_in;
   logic [COL_W:0]    nxt_ff, nxt_in;
   logic              load_ff, load_in;
   wr_type            last_wr_ff, last_wr_in;
   col_word_type      win_ff [WIN_SPAN];
   col_word_type      win_in [WIN_SPAN];
   col_word_type      rd_data_ff;
   col_word_type      mem [MAX_WIDTH];

   logic [DIM_W-1:0]  eff_w;
   logic [ROW_W-1:0]  eff_h;
   logic [RAD_W-1:0]  eff_r;
   logic              in_map;
   logic              step;
   logic              wr_en;
   logic [COL_W:0]    col_inc;
   logic [COL_W:0]    in_col_new;
   logic [ROW_W-1:0]  in_row_new;
   logic [SLOT_W-1:0] in_slot_new;
   logic [ROW_W:0]    near_row;
   logic [COL_W:0]    near_col_raw;
   logic [COL_W:0]    near_col;
   logic              due;
   logic              last;
   logic              shift;
   col_word_type      rd_merged;
   col_word_type      eff [WIN_SPAN+1];
   logic [RAD_W-1:0]  span_lo;
   logic [RAD_W-1:0]  span_hi;
   logic [ROW_W-1:0]  room;
   logic [SLOT_ROWS-1:0] row_ok;
   logic [WIN_SPAN-1:0]  col_ok;
   logic              hit;
   cls_type           center;

   assign eff_w = (width_ff == '0) ? DIM_W'(1) :
                  (width_ff > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_ff;
   assign eff_h = (height_ff == '0) ? ROW_W'(1) :
                  (height_ff > ROW_W'(HEIGHT_LIMIT)) ? ROW_W'(HEIGHT_LIMIT) : height_ff;
   assign eff_r = (radius_ff > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_ff;

   assign item_pop = item_valid && !load_ff && !rsp_full;
   assign in_map   = (in_row_ff < eff_h);
   assign step     = item_pop && !(in_map && item.pad);
   assign wr_en    = step && in_map;

   always_comb begin
      col_inc     = {1'b0, in_col_ff} + 1'b1;
      in_col_new  = {1'b0, in_col_ff};
      in_row_new  = in_row_ff;
      in_slot_new = in_slot_ff;
      if (step && (in_row_ff != '1)) begin
         if (col_inc >= eff_w) begin
            in_col_new  = '0;
            in_row_new  = in_row_ff + 1'b1;
            in_slot_new = (in_slot_ff == SLOT_W'(SLOT_ROWS - 1)) ? '0 : in_slot_ff + 1'b1;
         end else begin
            in_col_new = col_inc;
         end
      end
      near_row     = {1'b0, out_row_ff} + (ROW_W+1)'(eff_r);
      near_col_raw = {1'b0, out_col_ff} + (COL_W+1)'(eff_r);
      near_col     = (near_col_raw > eff_w - 1'b1) ? eff_w - 1'b1 : near_col_raw;
      due = step && (({1'b0, in_row_new} > near_row) ||
                     (({1'b0, in_row_new} == near_row) && (in_col_new > near_col)));
   end

   // Column window: entry k holds the column nxt_ff - WIN_SPAN + k; the extra
   // top entry comes straight from the memory read, patched by last cycle's write.
   always_comb begin
      rd_merged = rd_data_ff;
      if (last_wr_ff.valid && ({1'b0, last_wr_ff.col} == nxt_ff)) begin
         rd_merged[last_wr_ff.slot] = last_wr_ff.cls;
      end
      for (int k = 0; k <= WIN_SPAN; k++) begin
         if (k == WIN_SPAN) eff[k] = rd_merged;
         else eff[k] = win_ff[k];
         if (wr_en && (({1'b0, in_col_ff} + (COL_W+1)'(WIN_SPAN - k)) == nxt_ff)) begin
            eff[k][in_slot_ff] = item.cls;
         end
      end
   end

   always_comb begin
      logic [SLOT_W:0] gap;
      span_lo = (out_row_ff < ROW_W'(eff_r)) ? RAD_W'(out_row_ff) : eff_r;
      room    = eff_h - 1'b1 - out_row_ff;
      span_hi = (room < ROW_W'(eff_r)) ? RAD_W'(room) : eff_r;
      for (int s = 0; s < SLOT_ROWS; s++) begin
         if ((SLOT_W+1)'(s) >= {1'b0, out_slot_ff}) begin
            gap = (SLOT_W+1)'(s) - {1'b0, out_slot_ff};
         end else begin
            gap = (SLOT_W+1)'(s + SLOT_ROWS) - {1'b0, out_slot_ff};
         end
         row_ok[s] = (gap <= (SLOT_W+1)'(span_hi)) ||
                     ((span_lo != '0) &&
                      (gap >= (SLOT_W+1)'(SLOT_ROWS) - (SLOT_W+1)'(span_lo)));
      end
      for (int k = 0; k < WIN_SPAN; k++) begin
         if (k < MAX_RADIUS) begin
            col_ok[k] = (RAD_W'(MAX_RADIUS - k) <= eff_r) &&
                        ((COL_W+1)'(MAX_RADIUS - k) <= {1'b0, out_col_ff});
         end else begin
            col_ok[k] = (RAD_W'(k - MAX_RADIUS) <= eff_r) &&
                        (({1'b0, out_col_ff} + (COL_W+1)'(k - MAX_RADIUS)) <= eff_w - 1'b1);
         end
      end
      hit = 1'b0;
      for (int k = 0; k < WIN_SPAN; k++) begin
         for (int s = 0; s < SLOT_ROWS; s++) begin
            if (col_ok[k] && row_ok[s] && (eff[k][s] == CLS_OBST)) hit = 1'b1;
         end
      end
      center = eff[MAX_RADIUS][out_slot_ff];
   end

   assign last = (out_row_ff == eff_h - 1'b1) && ({1'b0, out_col_ff} == eff_w - 1'b1);

   assign rsp_push        = due;
   assign rsp.cell_class  = ((center == CLS_FREE) && hit) ? CLS_OBST : center;
   assign rsp.out_row     = OUT_W'(out_row_ff);
   assign rsp.out_col     = OUT_W'(out_col_ff);
   assign rsp.frame_last  = last;

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      radius_in   = radius_ff;
      in_row_in   = in_row_new;
      in_col_in   = COL_W'(in_col_new);
      in_slot_in  = in_slot_new;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      out_slot_in = out_slot_ff;
      nxt_in      = nxt_ff;
      load_in     = load_ff;
      shift       = 1'b0;
      last_wr_in  = '{valid: wr_en, col: in_col_ff, slot: in_slot_ff, cls: item.cls};

      if (load_ff) begin
         shift   = 1'b1;
         nxt_in  = nxt_ff + 1'b1;
         load_in = ((nxt_ff + 1'b1) != (COL_W+1)'(MAX_RADIUS + 1));
      end else if (due) begin
         if (last) begin
            in_row_in   = '0;
            in_col_in   = '0;
            in_slot_in  = '0;
            out_row_in  = '0;
            out_col_in  = '0;
            out_slot_in = '0;
            nxt_in      = (COL_W+1)'(MAX_RADIUS + 1);
         end else if (({1'b0, out_col_ff} + 1'b1) >= eff_w) begin
            out_col_in  = '0;
            out_row_in  = out_row_ff + 1'b1;
            out_slot_in = (out_slot_ff == SLOT_W'(SLOT_ROWS - 1)) ? '0 : out_slot_ff + 1'b1;
            nxt_in      = '0;
            load_in     = 1'b1;
         end else begin
            out_col_in = out_col_ff + 1'b1;
            shift      = 1'b1;
            nxt_in     = nxt_ff + 1'b1;
         end
      end

      if (csr.we && ((csr.index == CSR_GRID_WIDTH) || (csr.index == CSR_GRID_HEIGHT) ||
                     (csr.index == CSR_INFLATE_RADIUS))) begin
         unique case (csr.index)
            CSR_GRID_WIDTH:     width_in  = DIM_W'(csr.wdata);
            CSR_GRID_HEIGHT:    height_in = DIM_W'(csr.wdata);
            CSR_INFLATE_RADIUS: radius_in = RAD_W'(csr.wdata);
            default:            radius_in = radius_ff;
         endcase
         in_row_in   = '0;
         in_col_in   = '0;
         in_slot_in  = '0;
         out_row_in  = '0;
         out_col_in  = '0;
         out_slot_in = '0;
         nxt_in      = (COL_W+1)'(MAX_RADIUS + 1);
         load_in     = 1'b0;
      end

      for (int k = 0; k < WIN_SPAN; k++) begin
         win_in[k] = shift ? eff[k+1] : eff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         radius_ff   <= RADIUS_RESET;
         in_row_ff   <= '0;
         in_col_ff   <= '0;
         in_slot_ff  <= '0;
         out_row_ff  <= '0;
         out_col_ff  <= '0;
         out_slot_ff <= '0;
         nxt_ff      <= (COL_W+1)'(MAX_RADIUS + 1);
         load_ff     <= 1'b0;
         last_wr_ff  <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         radius_ff   <= radius_in;
         in_row_ff   <= in_row_in;
         in_col_ff   <= in_col_in;
         in_slot_ff  <= in_slot_in;
         out_row_ff  <= out_row_in;
         out_col_ff  <= out_col_in;
         out_slot_ff <= out_slot_in;
         nxt_ff      <= nxt_in;
         load_ff     <= load_in;
         last_wr_ff  <= last_wr_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < WIN_SPAN; k++) begin
         win_ff[k] <= win_in[k];
      end
   end

   // Line store: one column of all row slots per word, one read and one write a cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[in_col_ff][in_slot_ff] <= item.cls;
      end
      rd_data_ff <= mem[nxt_in[COL_W-1:0]];
   end

endmodule

`default_nettype wire

>>> src/ogi_rsp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ogi_rsp_queue import ogi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_word,
   output logic    full,
   output logic    empty,
   output rsp_type head_word,
   input  logic    pop
);

   rsp_type           q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] head_ff, head_in;
   logic [QPTR_W-1:0] tail_ff, tail_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push_ok;
   logic              pop_ok;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_word = q_ff[head_ff];
   assign push_ok   = push && !full;
   assign pop_ok    = pop && !empty;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push_ok) begin
         tail_in = (tail_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (pop_ok) begin
         head_in = (head_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push_ok && !pop_ok) count_in = count_ff + 1'b1;
      else if (!push_ok && pop_ok) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[tail_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

>>> src/occupancy_grid_inflation_top.sv
// A word that completes an output cell shows on the result side in the cycle after
// it is taken; results trail the input by radius rows plus radius cells.
// Throughput: one word per cycle while the result queue has room; words wait at the
// start of each output row after a frame's first while the column window reloads.
// Reset is synchronous and active high; it empties both queues, restarts the frame
// and sets the registers to width 512, height 512 and radius 5.
`timescale 1ns / 1ps
`default_nettype none

module occupancy_grid_inflation_top import ogi_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_mode,
   input  logic signed [RAW_W-1:0]   req_cell_value,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [1:0]                rsp_cell_class,
   output logic [OUT_W-1:0]          rsp_out_row,
   output logic [OUT_W-1:0]          rsp_out_col,
   output logic                      rsp_frame_last,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   logic     item_valid;
   item_type item;
   logic     item_pop;
   logic     rsp_full;
   logic     rsp_push;
   rsp_type  rsp_word;
   rsp_type  head_word;
   csr_type  csr;

   assign csr = '{we: csr_we, index: csr_index, wdata: csr_wdata};

   ogi_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_mode       (req_mode),
      .req_cell_value (req_cell_value),
      .item_valid     (item_valid),
      .item           (item),
      .item_pop       (item_pop)
   );

   ogi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp        (rsp_word)
   );

   ogi_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_word (rsp_word),
      .full      (rsp_full),
      .empty     (rsp_empty),
      .head_word (head_word),
      .pop       (rsp_pop)
   );

   assign rsp_cell_class = head_word.cell_class;
   assign rsp_out_row    = head_word.out_row;
   assign rsp_out_col    = head_word.out_col;
   assign rsp_frame_last = head_word.frame_last;

endmodule

`default_nettype wire

>>> src/ogi_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ogi_checker import ogi_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_full,
   input logic                    rsp_empty,
   input logic                    rsp_pop,
   input logic [1:0]              rsp_cell_class,
   input logic [OUT_W-1:0]        rsp_out_row,
   input logic [OUT_W-1:0]        rsp_out_col,
   input logic                    rsp_frame_last
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_class_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_cell_class == CLS_FREE) || (rsp_cell_class == CLS_OBST) ||
                     (rsp_cell_class == CLS_UNKNOWN))
      else $error("result word carries an undefined class");

   a_word_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_cell_class) &&
         $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_frame_last))
      else $error("waiting result word changed");

endmodule

bind occupancy_grid_inflation_top ogi_checker u_ogi_checker (.*);

`default_nettype wire

>>> tb/tb_occupancy_grid_inflation_top.sv
`timescale 1ns / 1ps

module tb_occupancy_grid_inflation_top;
   import ogi_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 24;
   localparam int LONG_HOLD = 400;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG = 2'd3;

   typedef struct {
      bit                      pad;
      logic signed [RAW_W-1:0] value;
   } grid_word_type;

   logic                     clock;
   logic                     reset;
   logic                     req_push;
   logic                     req_full;
   logic                     req_mode;
   logic signed [RAW_W-1:0]  req_cell_value;
   logic                     rsp_empty;
   logic                     rsp_pop;
   logic [1:0]               rsp_cell_class;
   logic [OUT_W-1:0]         rsp_out_row;
   logic [OUT_W-1:0]         rsp_out_col;
   logic                     rsp_frame_last;
   logic                     csr_we;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;

   occupancy_grid_inflation_top u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_mode(req_mode),
      .req_cell_value(req_cell_value),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_cell_class(rsp_cell_class),
      .rsp_out_row(rsp_out_row), .rsp_out_col(rsp_out_col),
      .rsp_frame_last(rsp_frame_last),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Shadow of the inflation filter.
   logic [1:0]  shadow_lines [SLOT_ROWS*MAX_WIDTH];
   int unsigned reg_width, reg_height, reg_radius;
   int unsigned in_row, in_col, out_row, out_col;

   grid_word_type word_q [$];
   rsp_type       cell_q [$];

   int  errors = 0;
   int  words_sent = 0;
   int  cells_seen = 0;
   int  frames_seen = 0;
   int  gen_frames = 0;
   int  idle_gap = 0;
   int  hold_left = 0;
   int  hold_req = 0;
   int  hold_done = 0;
   int  quiet_cycles = 0;
   bit  no_idle = 0;

   function automatic int unsigned eff_width();
      if (reg_width < 1) return 1;
      if (reg_width > MAX_WIDTH) return MAX_WIDTH;
      return reg_width;
   endfunction

   function automatic int unsigned eff_height();
      if (reg_height < 1) return 1;
      if (reg_height > HEIGHT_LIMIT) return HEIGHT_LIMIT;
      return reg_height;
   endfunction

   function automatic int unsigned eff_radius();
      return (reg_radius > MAX_RADIUS) ? MAX_RADIUS : reg_radius;
   endfunction

   function automatic logic [1:0] line_read(int unsigned row, int unsigned col);
      return shadow_lines[(row % SLOT_ROWS) * MAX_WIDTH + (col % MAX_WIDTH)];
   endfunction

   function automatic void restart_counts();
      in_row = 0;
      in_col = 0;
      out_row = 0;
      out_col = 0;
   endfunction

   function automatic void queue_word(input grid_word_type wd);
      word_q.insert(word_q.size(), wd);
   endfunction

   function automatic bit inflate_step(input bit pad, input logic [7:0] raw,
                                       output rsp_type res);
      int unsigned w, h, r, nr, nc, r0, r1, c0, c1;
      logic [1:0]  c;
      bit          last;
      w = eff_width();
      h = eff_height();
      r = eff_radius();
      res = '0;
      if (in_row < h) begin
         if (pad) return 0;
         if (raw == 8'd0) c = CLS_FREE;
         else if (raw == 8'd100) c = CLS_OBST;
         else c = CLS_UNKNOWN;
         shadow_lines[(in_row % SLOT_ROWS) * MAX_WIDTH + (in_col % MAX_WIDTH)] = c;
      end
      if (in_row < 1023) begin
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
      end
      nr = out_row + r;
      nc = out_col + r;
      if (nc > w - 1) nc = w - 1;
      if (!(in_row > nr || (in_row == nr && in_col > nc))) return 0;
      c = line_read(out_row, out_col);
      if (c == CLS_FREE) begin
         r0 = (out_row > r) ? out_row - r : 0;
         r1 = out_row + r;
         if (r1 > h - 1) r1 = h - 1;
         c0 = (out_col > r) ? out_col - r : 0;
         c1 = out_col + r;
         if (c1 > w - 1) c1 = w - 1;
         for (int unsigned i = r0; i <= r1; i++)
            for (int unsigned j = c0; j <= c1; j++)
               if (line_read(i, j) == CLS_OBST) c = CLS_OBST;
      end
      last = (out_row == h - 1) && (out_col == w - 1);
      res.cell_class = c;
      res.out_row = out_row[OUT_W-1:0];
      res.out_col = out_col[OUT_W-1:0];
      res.frame_last = last;
      if (last) begin
         restart_counts();
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
      return 1;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Driver.
   always @(posedge clock) begin
      rsp_type res;
      bit      took;
      bit      push_n;
      grid_word_type wd;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         took = req_push && !req_full;
         push_n = req_push && !took;
         if (took) begin
            words_sent++;
            if (inflate_step(req_mode, req_cell_value, res)) begin
               cell_q.insert(cell_q.size(), res);
            end
            idle_gap = no_idle ? 0 : $urandom_range(0, 11);
         end
         if (!req_push || took) begin
            if (idle_gap == 0 && word_q.size() > 0) begin
               wd = word_q.pop_front();
               req_mode <= wd.pad;
               req_cell_value <= wd.value;
               push_n = 1'b1;
            end else if (idle_gap > 0) begin
               idle_gap--;
            end
         end
         req_push <= push_n;
      end
   end

   // Monitor.
   always @(posedge clock) begin
      rsp_type got, want;
      bit      took;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         took = rsp_pop && !rsp_empty;
         if (took) begin
            got.cell_class = rsp_cell_class;
            got.out_row = rsp_out_row;
            got.out_col = rsp_out_col;
            got.frame_last = rsp_frame_last;
            cells_seen++;
            if (rsp_frame_last) frames_seen++;
            if (cell_q.size() == 0) begin
               $error("unexpected word: row %0d col %0d", rsp_out_row, rsp_out_col);
               errors++;
            end else begin
               want = cell_q.pop_front();
               if (got.cell_class !== want.cell_class) begin
                  $error("cell_class expected %0d actual %0d", want.cell_class,
                         got.cell_class);
                  errors++;
               end
               if (got.out_row !== want.out_row) begin
                  $error("out_row expected %0d actual %0d", want.out_row, got.out_row);
                  errors++;
               end
               if (got.out_col !== want.out_col) begin
                  $error("out_col expected %0d actual %0d", want.out_col, got.out_col);
                  errors++;
               end
               if (got.frame_last !== want.frame_last) begin
                  $error("frame_last expected %0d actual %0d", want.frame_last,
                         got.frame_last);
                  errors++;
               end
            end
            hold_left = no_idle ? 0 : $urandom_range(0, 11);
         end
         if (hold_done < hold_req) begin
            hold_done = hold_req;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL occupancy_grid_inflation_top");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_drained();
      while (word_q.size() > 0 || req_push || cell_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      wait_drained();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      csr_wdata <= ~val;
      case (idx)
         CSR_GRID_WIDTH: begin
            reg_width = val;
            restart_counts();
         end
         CSR_GRID_HEIGHT: begin
            reg_height = val;
            restart_counts();
         end
         CSR_INFLATE_RADIUS: begin
            reg_radius = val[RAD_W-1:0];
            restart_counts();
         end
         default: begin
         end
      endcase
   endtask

   task automatic set_grid(input int w, input int h, input int r);
      csr_write(CSR_GRID_WIDTH, CSR_DATA_W'(w));
      csr_write(CSR_GRID_HEIGHT, CSR_DATA_W'(h));
      csr_write(CSR_INFLATE_RADIUS, CSR_DATA_W'(r));
   endtask

   function automatic logic [7:0] draw_value();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 8'd0;
      if (p < 72) return 8'd100;
      return RAW_W'($urandom);
   endfunction

   // One map plus the exact number of trailing words that flush it, with pad words mixed in when noisy.
   task automatic queue_frame(input int map_cells, input bit noisy);
      grid_word_type wd;
      int flush;
      flush = eff_radius() * eff_width();
      for (int k = 0; k < map_cells; k++) begin
         if (noisy && $urandom_range(0, 99) < 8) begin
            wd.pad = 1'b1;
            wd.value = RAW_W'($urandom);
            queue_word(wd);
         end
         wd.pad = 1'b0;
         wd.value = draw_value();
         queue_word(wd);
      end
      for (int k = 0; k < flush; k++) begin
         wd.pad = noisy ? ($urandom_range(0, 99) < 70) : 1'b1;
         wd.value = RAW_W'($urandom);
         queue_word(wd);
      end
      if (noisy && $urandom_range(0, 3) == 0) begin
         wd.pad = 1'b1;
         wd.value = RAW_W'($urandom);
         queue_word(wd);
      end
      gen_frames++;
   endtask

   initial begin
      int w, h, r;
      reset = 1'b1;
      req_push = 1'b0;
      req_mode = 1'b0;
      req_cell_value = '0;
      rsp_pop = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      for (int k = 0; k < SLOT_ROWS * MAX_WIDTH; k++) shadow_lines[k] = CLS_FREE;
      reg_width = WIDTH_RESET;
      reg_height = HEIGHT_RESET;
      reg_radius = RADIUS_RESET;
      restart_counts();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Edge cases: single cell maps, zero and oversized sizes, radius extremes.
      set_grid(1, 1, 0);
      queue_frame(1, 1);
      set_grid(0, 0, 8);
      queue_frame(1, 1);
      set_grid(3, 2, 15);
      queue_frame(6, 1);
      csr_write(CSR_NO_REG, 10'h3FF);
      queue_frame(6, 1);
      set_grid(1023, 2, 0);
      queue_frame(40, 0);
      set_grid(1, 1023, 1);
      queue_frame(40, 1);
      set_grid(5, 4, 2);
      queue_frame(11, 1);
      set_grid(4, 3, 1);
      queue_frame(12, 1);

      // The receiver stops for a long stretch while the sender keeps going.
      wait_drained();
      set_grid(8, 6, 2);
      hold_req++;
      queue_frame(48, 0);
      queue_frame(48, 1);
      wait_drained();

      while (words_sent + word_q.size() < 750) begin
         if ($urandom_range(0, 2) != 0) begin
            w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023) % 25
                                            : $urandom_range(1, 16);
            h = $urandom_range(0, 9);
            r = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
            set_grid(w, h, r);
            no_idle = ($urandom_range(0, 4) == 0);
         end
         queue_frame(eff_width() * eff_height(), 1);
      end
      wait_drained();
      no_idle = 1'b0;
      if (cell_q.size() != 0) begin
         $error("%0d expected cells never arrived", cell_q.size());
         errors++;
      end

      $display("Streamed %0d words over %0d maps; checked %0d cells and %0d frame ends.",
               words_sent, gen_frames, cells_seen, frames_seen);
      if (errors == 0) begin
         $display("PASS occupancy_grid_inflation_top");
      end else begin
         $display("FAIL occupancy_grid_inflation_top");
      end
      $finish;
   end

endmodule
